FILE: rtl/core/tpp_pkg.sv
package tpp_pkg;

	// width that the larger horizontal magnitude is normalized to
	localparam int NORM_BITS = 31;

	// square root datapath: radicand and root widths
	localparam int SQ_WIDTH   = 64;
	localparam int ROOT_WIDTH = 32;

	// pole offset register
	localparam int POLE_WIDTH = 15;
	localparam logic [POLE_WIDTH-1:0] POLE_RESET = 15'd200;

endpackage

FILE: rtl/core/tpp_sqrt_pipe.sv
module tpp_sqrt_pipe #(
	parameter int SIDE_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [tpp_pkg::SQ_WIDTH-1:0]   in_value,
	input  logic [SIDE_W-1:0]              in_side,
	output logic                           out_valid,
	output logic [tpp_pkg::ROOT_WIDTH-1:0] out_root,
	output logic [SIDE_W-1:0]              out_side
);
	import tpp_pkg::*;

	// one root bit per stage, MSB first; rem holds value - root^2
	logic [SQ_WIDTH-1:0]   rem_s  [1:ROOT_WIDTH];
	logic [ROOT_WIDTH-1:0] root_s [1:ROOT_WIDTH];
	logic [SIDE_W-1:0]     side_s [1:ROOT_WIDTH];
	logic                  vld_s  [1:ROOT_WIDTH];

	for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_stage
		localparam int B = ROOT_WIDTH - 1 - i;
		logic [SQ_WIDTH-1:0]   rem_in;
		logic [ROOT_WIDTH-1:0] root_in;
		logic [SIDE_W-1:0]     side_in;
		logic                  vld_in;
		logic [SQ_WIDTH:0]     trial;
		logic                  take;

		if (i == 0) begin : g_first
			assign rem_in  = in_value;
			assign root_in = '0;
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[i];
			assign root_in = root_s[i];
			assign side_in = side_s[i];
			assign vld_in  = vld_s[i];
		end

		// (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
		assign trial = ((SQ_WIDTH+1)'(root_in) << (B + 1)) | ((SQ_WIDTH+1)'(1) << (2 * B));
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= take ? rem_in - trial[SQ_WIDTH-1:0] : rem_in;
			root_s[i+1] <= take ? (root_in | (ROOT_WIDTH'(1) << B)) : root_in;
			side_s[i+1] <= side_in;
		end
	end

	assign out_valid = vld_s[ROOT_WIDTH];
	assign out_root  = root_s[ROOT_WIDTH];
	assign out_side  = side_s[ROOT_WIDTH];

endmodule

FILE: rtl/core/tpp_div2_pipe.sv
module tpp_div2_pipe #(
	parameter int NUM_W  = 63,
	parameter int DEN_W  = 33,
	parameter int QUO_W  = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num_a,
	input  logic [NUM_W-1:0]  in_num_b,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo_a,
	output logic [QUO_W-1:0]  out_quo_b,
	output logic [SIDE_W-1:0] out_side
);
	// two restoring dividers sharing one denominator, one quotient bit per stage;
	// the numerator must be below den * 2^QUO_W
	localparam int RW = DEN_W + QUO_W;

	logic [RW-1:0]     rem_a_s [1:QUO_W];
	logic [RW-1:0]     rem_b_s [1:QUO_W];
	logic [QUO_W-1:0]  quo_a_s [1:QUO_W];
	logic [QUO_W-1:0]  quo_b_s [1:QUO_W];
	logic [DEN_W-1:0]  den_s   [1:QUO_W];
	logic [SIDE_W-1:0] side_s  [1:QUO_W];
	logic              vld_s   [1:QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int B = QUO_W - 1 - i;
		logic [RW-1:0]     rem_a_in;
		logic [RW-1:0]     rem_b_in;
		logic [QUO_W-1:0]  quo_a_in;
		logic [QUO_W-1:0]  quo_b_in;
		logic [DEN_W-1:0]  den_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [RW-1:0]     trial;
		logic              take_a;
		logic              take_b;

		if (i == 0) begin : g_first
			assign rem_a_in = RW'(in_num_a);
			assign rem_b_in = RW'(in_num_b);
			assign quo_a_in = '0;
			assign quo_b_in = '0;
			assign den_in   = in_den;
			assign side_in  = in_side;
			assign vld_in   = in_valid;
		end else begin : g_next
			assign rem_a_in = rem_a_s[i];
			assign rem_b_in = rem_b_s[i];
			assign quo_a_in = quo_a_s[i];
			assign quo_b_in = quo_b_s[i];
			assign den_in   = den_s[i];
			assign side_in  = side_s[i];
			assign vld_in   = vld_s[i];
		end

		assign trial  = RW'(den_in) << B;
		assign take_a = rem_a_in >= trial;
		assign take_b = rem_b_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_a_s[i+1] <= take_a ? rem_a_in - trial : rem_a_in;
			rem_b_s[i+1] <= take_b ? rem_b_in - trial : rem_b_in;
			quo_a_s[i+1] <= take_a ? (quo_a_in | (QUO_W'(1) << B)) : quo_a_in;
			quo_b_s[i+1] <= take_b ? (quo_b_in | (QUO_W'(1) << B)) : quo_b_in;
			den_s[i+1]   <= den_in;
			side_s[i+1]  <= side_in;
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo_a = quo_a_s[QUO_W];
	assign out_quo_b = quo_b_s[QUO_W];
	assign out_side  = side_s[QUO_W];

endmodule

FILE: rtl/core/tangent_plane_point_projection_unit.sv
// Tangent-plane projection of a target point into the local frame of a center point.
// Each item is a center (center_x/y/z) and a target (target_x/y/z), signed fixed point
// with FRAC_BITS fraction bits; the result is plane_u (along n x ey) and plane_v (along
// the inward axis ey), same format, saturated. The frame normal runs from a pole
// pole_offset whole units below the center up to the center; a center with x = z = 0
// is treated as having z = -1.0, in the frame and in the target difference.
// Handshake: an item is taken on any clock edge with start high; busy is always low,
// so one item may enter every cycle. Each result shows on plane_u/plane_v for exactly
// one cycle with done high, in input order, and cannot be held off by the receiver.
// Unit vectors carry UNIT_FRAC fraction bits, where UNIT_FRAC = 30 for COORD_WIDTH <= 28,
// else 58 - COORD_WIDTH. The datapath holds two 32-stage square root pipes (one root
// bit per stage) and two restoring divider pipes (one quotient bit per stage). Write
// pole_offset only while no item is in flight.
module tangent_plane_point_projection_unit #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cfg_we,
	input  logic [tpp_pkg::POLE_WIDTH-1:0]     cfg_data,
	input  logic signed [COORD_WIDTH-1:0]      center_x,
	input  logic signed [COORD_WIDTH-1:0]      center_y,
	input  logic signed [COORD_WIDTH-1:0]      center_z,
	input  logic signed [COORD_WIDTH-1:0]      target_x,
	input  logic signed [COORD_WIDTH-1:0]      target_y,
	input  logic signed [COORD_WIDTH-1:0]      target_z,
	output logic                               done,
	output logic signed [COORD_WIDTH-1:0]      plane_u,
	output logic signed [COORD_WIDTH-1:0]      plane_v
);
	import tpp_pkg::*;

	// fraction bits of unit vectors
	localparam int UF     = (COORD_WIDTH <= 28) ? 30 : 58 - COORD_WIDTH;
	// center z may be replaced by -1.0, which needs FRAC_BITS+1 bits
	localparam int CZ_W   = (COORD_WIDTH > FRAC_BITS + 1) ? COORD_WIDTH : FRAC_BITS + 1;
	localparam int DXW    = COORD_WIDTH + 1;
	localparam int DZW    = CZ_W + 1;
	localparam int TAIL_W = 2 + 2 * DXW + DZW;
	localparam int SH_W   = 8;
	localparam int QW     = UF + 1;
	localparam int QS     = UF + 2;
	localparam int NUM_W  = NORM_BITS + UF + 2;
	localparam int DEN_W  = ROOT_WIDTH + 1;
	localparam int PW     = QS + DZW;
	localparam int SW     = PW + 2;
	localparam int DR_W   = POLE_WIDTH + FRAC_BITS;
	localparam int R1_SIDE_W = 2 * NORM_BITS + SH_W + TAIL_W;
	localparam int D1_SIDE_W = ROOT_WIDTH + SH_W + TAIL_W;
	localparam int R2_SIDE_W = 2 * NORM_BITS + 2 * QW + TAIL_W;
	localparam int D2_SIDE_W = 2 * QW + TAIL_W;
	localparam int LATENCY   = 17 + 2 * ROOT_WIDTH + 2 * QW;

	localparam logic signed [CZ_W-1:0] CZ_AXIS = -$signed(CZ_W'(1) << FRAC_BITS);
	localparam logic signed [SW-1:0]   HALF    = $signed(SW'(1) << (UF - 1));
	localparam logic signed [SW-1:0]   HALF_M1 = HALF - SW'(1);
	localparam logic [2*QW-1:0]        HALF_P  = (2*QW)'(1) << (UF - 1);

	function automatic logic [6:0] bit_len(input logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(i + 1);
			end
		end
		return n;
	endfunction

	// left shift for n >= 0, truncating right shift otherwise
	function automatic logic [63:0] shift_by(input logic [63:0] v, input logic signed [SH_W-1:0] n);
		logic [SH_W-1:0] nn;
		nn = SH_W'(-n);
		if (n >= 0) begin
			return v << n;
		end else begin
			return v >> nn;
		end
	endfunction

	function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] x);
		logic [SW-COORD_WIDTH:0] top;
		top = x[SW-1:COORD_WIDTH-1];
		if (top == '0 || top == '1) begin
			return x[COORD_WIDTH-1:0];
		end else if (x[SW-1]) begin
			return {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	endfunction

	assign busy = 1'b0;

	// pole offset register
	logic [POLE_WIDTH-1:0] pole_q;
	logic [DR_W-1:0]       d_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q <= POLE_RESET;
		end else if (cfg_we) begin
			pole_q <= cfg_data;
		end
	end

	assign d_raw = DR_W'(pole_q) << FRAC_BITS;

	// valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16, vld_s17;
	logic r1_valid, d1_valid, r2_valid, d2_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= r1_valid;
			vld_s7  <= d1_valid;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= r2_valid;
			vld_s12 <= d2_valid;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	// s1: axis special case, differences, magnitudes
	// tail = {cx sign, cz sign, dx, dy, dz}, carried to the dot products
	logic signed [CZ_W-1:0] cx_e, cz_f;
	logic signed [CZ_W:0]   ax_full, az_full;
	logic signed [DXW-1:0]  dx_c, dy_c;
	logic signed [DZW-1:0]  dz_c;
	logic [CZ_W-1:0]        ax_s1, az_s1;
	logic [TAIL_W-1:0]      tail_s1;

	always_comb begin
		cx_e    = CZ_W'(center_x);
		cz_f    = (center_x == '0 && center_z == '0) ? CZ_AXIS : CZ_W'(center_z);
		ax_full = (CZ_W+1)'(cx_e);
		az_full = (CZ_W+1)'(cz_f);
		dx_c    = DXW'(target_x) - DXW'(center_x);
		dy_c    = DXW'(target_y) - DXW'(center_y);
		dz_c    = DZW'(target_z) - DZW'(cz_f);
	end

	always_ff @(posedge clk) begin
		ax_s1   <= cx_e[CZ_W-1] ? CZ_W'(-ax_full) : CZ_W'(ax_full);
		az_s1   <= cz_f[CZ_W-1] ? CZ_W'(-az_full) : CZ_W'(az_full);
		tail_s1 <= {cx_e[CZ_W-1], cz_f[CZ_W-1], dx_c, dy_c, dz_c};
	end

	// s2: shift that brings the larger magnitude to NORM_BITS bits
	logic [CZ_W-1:0]        mx, ax_s2, az_s2;
	logic signed [SH_W-1:0] lsh_s2;
	logic [TAIL_W-1:0]      tail_s2;

	assign mx = (ax_s1 > az_s1) ? ax_s1 : az_s1;

	always_ff @(posedge clk) begin
		lsh_s2  <= $signed(SH_W'(NORM_BITS)) - $signed({1'b0, bit_len(64'(mx))});
		ax_s2   <= ax_s1;
		az_s2   <= az_s1;
		tail_s2 <= tail_s1;
	end

	// s3: normalize
	logic [NORM_BITS-1:0]   ax_s3, az_s3;
	logic signed [SH_W-1:0] lsh_s3;
	logic [TAIL_W-1:0]      tail_s3;

	always_ff @(posedge clk) begin
		ax_s3   <= NORM_BITS'(shift_by(64'(ax_s2), lsh_s2));
		az_s3   <= NORM_BITS'(shift_by(64'(az_s2), lsh_s2));
		lsh_s3  <= lsh_s2;
		tail_s3 <= tail_s2;
	end

	// s4: squares
	logic [2*NORM_BITS-1:0] sqa_s4, sqz_s4;
	logic [NORM_BITS-1:0]   ax_s4, az_s4;
	logic signed [SH_W-1:0] lsh_s4;
	logic [TAIL_W-1:0]      tail_s4;

	always_ff @(posedge clk) begin
		sqa_s4  <= ax_s3 * ax_s3;
		sqz_s4  <= az_s3 * az_s3;
		ax_s4   <= ax_s3;
		az_s4   <= az_s3;
		lsh_s4  <= lsh_s3;
		tail_s4 <= tail_s3;
	end

	// s5: sum of squares
	logic [SQ_WIDTH-1:0]    sum_s5;
	logic [NORM_BITS-1:0]   ax_s5, az_s5;
	logic signed [SH_W-1:0] lsh_s5;
	logic [TAIL_W-1:0]      tail_s5;

	always_ff @(posedge clk) begin
		sum_s5  <= SQ_WIDTH'(sqa_s4) + SQ_WIDTH'(sqz_s4);
		ax_s5   <= ax_s4;
		az_s5   <= az_s4;
		lsh_s5  <= lsh_s4;
		tail_s5 <= tail_s4;
	end

	// h = |(x, z)| at the normalized scale
	logic [ROOT_WIDTH-1:0]  h_r1;
	logic [R1_SIDE_W-1:0]   r1_side;
	logic [NORM_BITS-1:0]   ax_r1, az_r1;
	logic signed [SH_W-1:0] lsh_r1;
	logic [TAIL_W-1:0]      tail_r1;

	tpp_sqrt_pipe #(
		.SIDE_W (R1_SIDE_W)
	) u_sqrt_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_value  (sum_s5),
		.in_side   ({ax_s5, az_s5, lsh_s5, tail_s5}),
		.out_valid (r1_valid),
		.out_root  (h_r1),
		.out_side  (r1_side)
	);

	assign {ax_r1, az_r1, lsh_r1, tail_r1} = r1_side;

	// s6: rounding numerators for A = x/h and B = z/h
	logic [NUM_W-1:0]       na_s6, nb_s6;
	logic [DEN_W-1:0]       den_s6;
	logic [ROOT_WIDTH-1:0]  h_s6;
	logic signed [SH_W-1:0] lsh_s6;
	logic [TAIL_W-1:0]      tail_s6;

	always_ff @(posedge clk) begin
		na_s6   <= (NUM_W'(ax_r1) << (UF + 1)) + NUM_W'(h_r1);
		nb_s6   <= (NUM_W'(az_r1) << (UF + 1)) + NUM_W'(h_r1);
		den_s6  <= {h_r1, 1'b0};
		h_s6    <= h_r1;
		lsh_s6  <= lsh_r1;
		tail_s6 <= tail_r1;
	end

	logic [QW-1:0]          a_d1, b_d1;
	logic [D1_SIDE_W-1:0]   d1_side;
	logic [ROOT_WIDTH-1:0]  h_d1;
	logic signed [SH_W-1:0] lsh_d1;
	logic [TAIL_W-1:0]      tail_d1;

	tpp_div2_pipe #(
		.NUM_W  (NUM_W),
		.DEN_W  (DEN_W),
		.QUO_W  (QW),
		.SIDE_W (D1_SIDE_W)
	) u_div_ab (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.in_num_a  (na_s6),
		.in_num_b  (nb_s6),
		.in_den    (den_s6),
		.in_side   ({h_s6, lsh_s6, tail_s6}),
		.out_valid (d1_valid),
		.out_quo_a (a_d1),
		.out_quo_b (b_d1),
		.out_side  (d1_side)
	);

	assign {h_d1, lsh_d1, tail_d1} = d1_side;

	// s7: common scale for (h, D)
	logic signed [SH_W-1:0] eh, ed, mxe, sc;
	logic signed [SH_W-1:0] shh_s7, shd_s7;
	logic [ROOT_WIDTH-1:0]  h_s7;
	logic [QW-1:0]          a_s7, b_s7;
	logic [TAIL_W-1:0]      tail_s7;

	always_comb begin
		eh  = $signed({1'b0, bit_len(64'(h_d1))}) - lsh_d1;
		ed  = $signed({1'b0, bit_len(64'(d_raw))});
		mxe = (eh > ed) ? eh : ed;
		sc  = $signed(SH_W'(NORM_BITS)) - mxe;
	end

	always_ff @(posedge clk) begin
		shh_s7  <= sc - lsh_d1;
		shd_s7  <= sc;
		h_s7    <= h_d1;
		a_s7    <= a_d1;
		b_s7    <= b_d1;
		tail_s7 <= tail_d1;
	end

	// s8: scale
	logic [NORM_BITS-1:0] h2_s8, d2_s8;
	logic [QW-1:0]        a_s8, b_s8;
	logic [TAIL_W-1:0]    tail_s8;

	always_ff @(posedge clk) begin
		h2_s8   <= NORM_BITS'(shift_by(64'(h_s7), shh_s7));
		d2_s8   <= NORM_BITS'(shift_by(64'(d_raw), shd_s7));
		a_s8    <= a_s7;
		b_s8    <= b_s7;
		tail_s8 <= tail_s7;
	end

	// s9: squares
	logic [2*NORM_BITS-1:0] sqh_s9, sqd_s9;
	logic [NORM_BITS-1:0]   h2_s9, d2_s9;
	logic [QW-1:0]          a_s9, b_s9;
	logic [TAIL_W-1:0]      tail_s9;

	always_ff @(posedge clk) begin
		sqh_s9  <= h2_s8 * h2_s8;
		sqd_s9  <= d2_s8 * d2_s8;
		h2_s9   <= h2_s8;
		d2_s9   <= d2_s8;
		a_s9    <= a_s8;
		b_s9    <= b_s8;
		tail_s9 <= tail_s8;
	end

	// s10: sum
	logic [SQ_WIDTH-1:0]  sum_s10;
	logic [NORM_BITS-1:0] h2_s10, d2_s10;
	logic [QW-1:0]        a_s10, b_s10;
	logic [TAIL_W-1:0]    tail_s10;

	always_ff @(posedge clk) begin
		sum_s10  <= SQ_WIDTH'(sqh_s9) + SQ_WIDTH'(sqd_s9);
		h2_s10   <= h2_s9;
		d2_s10   <= d2_s9;
		a_s10    <= a_s9;
		b_s10    <= b_s9;
		tail_s10 <= tail_s9;
	end

	// m = |(h, D)|
	logic [ROOT_WIDTH-1:0] m_r2;
	logic [R2_SIDE_W-1:0]  r2_side;
	logic [NORM_BITS-1:0]  h2_r2, d2_r2;
	logic [QW-1:0]         a_r2, b_r2;
	logic [TAIL_W-1:0]     tail_r2;

	tpp_sqrt_pipe #(
		.SIDE_W (R2_SIDE_W)
	) u_sqrt_m (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s10),
		.in_value  (sum_s10),
		.in_side   ({h2_s10, d2_s10, a_s10, b_s10, tail_s10}),
		.out_valid (r2_valid),
		.out_root  (m_r2),
		.out_side  (r2_side)
	);

	assign {h2_r2, d2_r2, a_r2, b_r2, tail_r2} = r2_side;

	// s11: numerators for s = h/m and c = D/m
	logic [NUM_W-1:0]  ns_s11, nc_s11;
	logic [DEN_W-1:0]  den_s11;
	logic [QW-1:0]     a_s11, b_s11;
	logic [TAIL_W-1:0] tail_s11;

	always_ff @(posedge clk) begin
		ns_s11   <= (NUM_W'(h2_r2) << (UF + 1)) + NUM_W'(m_r2);
		nc_s11   <= (NUM_W'(d2_r2) << (UF + 1)) + NUM_W'(m_r2);
		den_s11  <= {m_r2, 1'b0};
		a_s11    <= a_r2;
		b_s11    <= b_r2;
		tail_s11 <= tail_r2;
	end

	logic [QW-1:0]        s_d2, c_d2, a_d2, b_d2;
	logic [D2_SIDE_W-1:0] d2_side;
	logic [TAIL_W-1:0]    tail_d2;

	tpp_div2_pipe #(
		.NUM_W  (NUM_W),
		.DEN_W  (DEN_W),
		.QUO_W  (QW),
		.SIDE_W (D2_SIDE_W)
	) u_div_sc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s11),
		.in_num_a  (ns_s11),
		.in_num_b  (nc_s11),
		.in_den    (den_s11),
		.in_side   ({a_s11, b_s11, tail_s11}),
		.out_valid (d2_valid),
		.out_quo_a (s_d2),
		.out_quo_b (c_d2),
		.out_side  (d2_side)
	);

	assign {a_d2, b_d2, tail_d2} = d2_side;

	// s12: A*c and B*c magnitudes
	logic [2*QW-1:0]   pac_s12, pbc_s12;
	logic [QW-1:0]     a_s12, b_s12, s_s12;
	logic [TAIL_W-1:0] tail_s12;

	always_ff @(posedge clk) begin
		pac_s12  <= a_d2 * c_d2;
		pbc_s12  <= b_d2 * c_d2;
		a_s12    <= a_d2;
		b_s12    <= b_d2;
		s_s12    <= s_d2;
		tail_s12 <= tail_d2;
	end

	// s13: signed axis components; ey x and z get the opposite sign of A and B
	logic              cxn12, czn12;
	logic [QW-1:0]     eyx_mag, eyz_mag;
	logic signed [QS-1:0] aq_s13, bq_s13, eyx_s13, eyz_s13, sq_s13;
	logic [TAIL_W-1:0] tail_s13;

	assign cxn12   = tail_s12[TAIL_W-1];
	assign czn12   = tail_s12[TAIL_W-2];
	assign eyx_mag = QW'((pac_s12 + HALF_P) >> UF);
	assign eyz_mag = QW'((pbc_s12 + HALF_P) >> UF);

	always_ff @(posedge clk) begin
		aq_s13   <= cxn12 ? -$signed(QS'(a_s12)) : $signed(QS'(a_s12));
		bq_s13   <= czn12 ? -$signed(QS'(b_s12)) : $signed(QS'(b_s12));
		eyx_s13  <= cxn12 ? $signed(QS'(eyx_mag)) : -$signed(QS'(eyx_mag));
		eyz_s13  <= czn12 ? $signed(QS'(eyz_mag)) : -$signed(QS'(eyz_mag));
		sq_s13   <= $signed(QS'(s_s12));
		tail_s13 <= tail_s12;
	end

	// s14: dot product terms
	logic signed [DXW-1:0] dx13, dy13;
	logic signed [DZW-1:0] dz13;
	logic signed [PW-1:0]  p1_s14, p2_s14, p3_s14, p4_s14, p5_s14;

	assign dz13 = $signed(tail_s13[DZW-1:0]);
	assign dy13 = $signed(tail_s13[DZW +: DXW]);
	assign dx13 = $signed(tail_s13[DZW+DXW +: DXW]);

	always_ff @(posedge clk) begin
		p1_s14 <= aq_s13 * dz13;
		p2_s14 <= bq_s13 * dx13;
		p3_s14 <= eyx_s13 * dx13;
		p4_s14 <= sq_s13 * dy13;
		p5_s14 <= eyz_s13 * dz13;
	end

	// s15: sums
	logic signed [SW-1:0] u_s15, v_s15;

	always_ff @(posedge clk) begin
		u_s15 <= SW'(p1_s14) - SW'(p2_s14);
		v_s15 <= SW'(p3_s14) + SW'(p4_s14) + SW'(p5_s14);
	end

	// s16: round half away from zero; for negatives add half minus one, then floor
	logic signed [SW-1:0] u_s16, v_s16;

	always_ff @(posedge clk) begin
		u_s16 <= (u_s15 + (u_s15[SW-1] ? HALF_M1 : HALF)) >>> UF;
		v_s16 <= (v_s15 + (v_s15[SW-1] ? HALF_M1 : HALF)) >>> UF;
	end

	// s17: saturate into the output register
	logic [COORD_WIDTH-1:0] u_s17, v_s17;

	always_ff @(posedge clk) begin
		u_s17 <= sat(u_s16);
		v_s17 <= sat(v_s16);
	end

	assign done    = vld_s17;
	assign plane_u = $signed(u_s17);
	assign plane_v = $signed(v_s17);

	// fixed latency, nothing invented
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching item");

	// normalized horizontal length has its top bit in one of the two top places
	a_h_norm: assert property (@(posedge clk) disable iff (!arst_n)
		r1_valid |-> (h_r1[ROOT_WIDTH-1] || h_r1[ROOT_WIDTH-2]))
		else $error("horizontal length not normalized");

	a_m_norm: assert property (@(posedge clk) disable iff (!arst_n)
		r2_valid |-> (m_r2[ROOT_WIDTH-1] || m_r2[ROOT_WIDTH-2]))
		else $error("frame length not normalized");

	// unit components never exceed one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(d1_valid || d2_valid) |->
			(a_d1 <= (QW'(1) << UF) && b_d1 <= (QW'(1) << UF) &&
			 s_d2 <= (QW'(1) << UF) && c_d2 <= (QW'(1) << UF)) || !d1_valid || !d2_valid)
		else $error("unit component above one");

endmodule
